FILE: hw/rtl/efg_pkg.sv
// Shared types, codes and constants of the event flag group unit.
`default_nettype none

package efg_pkg;

  localparam int unsigned WAITERS_DEF   = 8;
  localparam int unsigned TASK_BITS_DEF = 8;
  localparam int unsigned FLAG_W        = 32;
  localparam int unsigned TASK_FIELD_W  = 8;
  localparam int unsigned TOTAL_W       = 4;
  localparam int unsigned MODE_W        = 3;
  localparam int unsigned IN_DATA_W     = 48;
  localparam int unsigned OUT_DATA_W    = 80;
  localparam int unsigned APB_ADDR_W    = 3;
  localparam int unsigned APB_DATA_W    = 32;

  typedef enum logic [1:0] {
    CMD_WAIT   = 2'd0,
    CMD_TRY    = 2'd1,
    CMD_NOTIFY = 2'd2,
    CMD_FLUSH  = 2'd3
  } efg_cmd_e;

  typedef enum logic [1:0] {
    KIND_SUM   = 2'd0,
    KIND_WOKEN = 2'd1,
    KIND_REL   = 2'd2
  } efg_kind_e;

  typedef enum logic [2:0] {
    STAT_OK      = 3'd0,
    STAT_UNAVAIL = 3'd1,
    STAT_PENDING = 3'd2,
    STAT_FULL    = 3'd3,
    STAT_DELETED = 3'd4
  } efg_status_e;

  typedef struct packed {
    logic take;
    logic all;
    logic set;
  } efg_mode_t;

  typedef struct packed {
    logic              ok;
    logic [FLAG_W-1:0] matched;
    logic [FLAG_W-1:0] flags_next;
  } efg_chk_t;

endpackage

`default_nettype wire

FILE: hw/rtl/efg_cell.sv
// One waiter cell of the chain: load a new entry or take the neighbor's entry.
`default_nettype none

module efg_cell #(
  parameter int unsigned WIDTH = 43
) (
  input  wire logic             clk_i,
  input  wire logic             shift_i,
  input  wire logic             load_i,
  input  wire logic [WIDTH-1:0] load_data_i,
  input  wire logic [WIDTH-1:0] next_data_i,
  output logic      [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (load_i) begin
      data_d = load_data_i;
    end else if (shift_i) begin
      data_d = next_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

FILE: hw/rtl/efg_check.sv
// Flag check: match a request to the flag word; take consumes on success.
`default_nettype none

module efg_check import efg_pkg::*; (
  input  wire logic [FLAG_W-1:0] flags_i,
  input  wire efg_mode_t         mode_i,
  input  wire logic [FLAG_W-1:0] mask_i,
  output efg_chk_t               res_o
);

  logic [FLAG_W-1:0] hit;
  logic              ok;

  always_comb begin
    hit = mode_i.set ? (flags_i & mask_i) : (~flags_i & mask_i);
    ok  = mode_i.all ? (hit == mask_i) : (hit != '0);
    res_o.ok         = ok;
    res_o.matched    = hit;
    res_o.flags_next = flags_i;
    if (ok && mode_i.take) begin
      res_o.flags_next = mode_i.set ? (flags_i & ~mask_i) : (flags_i | mask_i);
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/event_flag_group_unit.sv
// Top level of the event flag group unit: control, flag word and waiter chain.
// Wait and try requests are answered in the cycle after acceptance. Waiters
// sit in a chain of WAITERS cells in arrival order; the head cell feeds one
// shared flag check. Notify makes one pass that rotates the chain and checks
// each waiter in turn, a second pass that rotates again and sends the woken
// ones, then the summary. Flush releases each waiter, then sends the summary.
// Output stalls hold the sending of woken and released waiters and of the
// summary. A write of initial_flags loads the flag word at once.
`default_nettype none

module event_flag_group_unit import efg_pkg::*; #(
  parameter int unsigned WAITERS      = WAITERS_DEF,
  parameter int unsigned TASK_ID_BITS = TASK_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // tdata: task_id[7:0], want_set[8], want_all[9], consume[10], mask[42:11],
  //        set_not_clear[43], zero fill
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: cmd[1:0]
  input  wire logic [1:0]            s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // tdata: out_task[7:0], status[10:8], matched_flags[42:11],
  //        flags_now[74:43], waiter_total[78:75], zero fill
  output logic      [OUT_DATA_W-1:0] m_axis_tdata,
  // tuser: kind[1:0]
  output logic      [1:0]            m_axis_tuser,
  output logic                       m_axis_tlast,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int unsigned CNT_W  = $clog2(WAITERS + 1);
  localparam int unsigned IDX_W  = (WAITERS > 1) ? $clog2(WAITERS) : 1;
  localparam int unsigned MASK_L = 0;
  localparam int unsigned MODE_L = FLAG_W;
  localparam int unsigned TASK_L = FLAG_W + MODE_W;
  localparam int unsigned WOKE_B = TASK_L + TASK_ID_BITS;
  localparam int unsigned SLOT_W = WOKE_B + 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_EMIT  = 3'd2;
  localparam logic [2:0] ST_FLUSH = 3'd3;
  localparam logic [2:0] ST_SUM   = 3'd4;

  logic [2:0]              state_q, state_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [CNT_W-1:0]        step_q, step_d;
  logic [CNT_W-1:0]        final_q, final_d;
  logic [FLAG_W-1:0]       flag_q, flag_d;
  logic [FLAG_W-1:0]       ini_q, ini_d;

  logic                    ov_q, ov_d;
  efg_kind_e               okind_q, okind_d;
  logic [TASK_FIELD_W-1:0] otask_q, otask_d;
  efg_status_e             ostat_q, ostat_d;
  logic [FLAG_W-1:0]       omatch_q, omatch_d;
  logic [FLAG_W-1:0]       oflags_q, oflags_d;
  logic [TOTAL_W-1:0]      ototal_q, ototal_d;
  logic                    olast_q, olast_d;

  logic [SLOT_W-1:0]       cell_data [WAITERS];
  logic [SLOT_W-1:0]       head;
  logic                    shift;
  logic                    load_en;
  logic [IDX_W-1:0]        load_idx;
  logic [SLOT_W-1:0]       load_data;

  logic [FLAG_W-1:0]       chk_flags;
  efg_mode_t               chk_mode;
  logic [FLAG_W-1:0]       chk_mask;
  efg_chk_t                chk;

  logic                    out_free;
  logic                    accept;
  logic                    cfg_wr;
  efg_cmd_e                in_cmd;
  logic [TASK_ID_BITS-1:0] in_task;
  efg_mode_t               in_mode;
  logic [FLAG_W-1:0]       in_mask;
  logic                    in_setbits;
  logic [TASK_ID_BITS-1:0] head_task;
  efg_mode_t               head_mode;
  logic [FLAG_W-1:0]       head_mask;
  logic                    head_woken;

  assign in_cmd     = efg_cmd_e'(s_axis_tuser);
  assign in_task    = TASK_ID_BITS'(s_axis_tdata[TASK_FIELD_W-1:0]);
  assign in_mode    = efg_mode_t'({s_axis_tdata[10], s_axis_tdata[9], s_axis_tdata[8]});
  assign in_mask    = s_axis_tdata[42:11];
  assign in_setbits = s_axis_tdata[43];

  assign head       = cell_data[0];
  assign head_mask  = head[MASK_L +: FLAG_W];
  assign head_mode  = efg_mode_t'(head[MODE_L +: MODE_W]);
  assign head_task  = head[TASK_L +: TASK_ID_BITS];
  assign head_woken = head[WOKE_B];

  assign out_free      = !ov_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_wr        = psel && penable && pwrite && pready && !paddr[2];
  assign pready        = 1'b1;
  assign prdata        = paddr[2] ? '0 : ini_q;

  for (genvar g = 0; g < WAITERS; g++) begin : g_cell
    logic [SLOT_W-1:0] next_data;
    if (g == WAITERS - 1) begin : g_end
      assign next_data = '0;
    end else begin : g_mid
      assign next_data = cell_data[g+1];
    end
    efg_cell #(
      .WIDTH(SLOT_W)
    ) u_cell (
      .clk_i       (clk_i),
      .shift_i     (shift),
      .load_i      (load_en && (load_idx == IDX_W'(g))),
      .load_data_i (load_data),
      .next_data_i (next_data),
      .data_o      (cell_data[g])
    );
  end

  efg_check u_check (
    .flags_i (chk_flags),
    .mode_i  (chk_mode),
    .mask_i  (chk_mask),
    .res_o   (chk)
  );

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    step_d    = step_q;
    final_d   = final_q;
    flag_d    = flag_q;
    ini_d     = ini_q;
    ov_d      = ov_q && !m_axis_tready;
    okind_d   = okind_q;
    otask_d   = otask_q;
    ostat_d   = ostat_q;
    omatch_d  = omatch_q;
    oflags_d  = oflags_q;
    ototal_d  = ototal_q;
    olast_d   = olast_q;
    shift     = 1'b0;
    load_en   = 1'b0;
    load_idx  = IDX_W'(cnt_q - CNT_W'(1));
    load_data = head;
    chk_flags = flag_q;
    chk_mode  = in_mode;
    chk_mask  = in_mask;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_cmd)
            CMD_WAIT, CMD_TRY: begin
              ostat_d = STAT_OK;
              if (chk.ok) begin
                flag_d = chk.flags_next;
              end else if (in_cmd == CMD_TRY) begin
                ostat_d = STAT_UNAVAIL;
              end else if (cnt_q < CNT_W'(WAITERS)) begin
                load_en   = 1'b1;
                load_idx  = IDX_W'(cnt_q);
                load_data = {1'b0, in_task, in_mode, in_mask};
                cnt_d     = cnt_q + CNT_W'(1);
                ostat_d   = STAT_PENDING;
              end else begin
                ostat_d = STAT_FULL;
              end
              ov_d     = 1'b1;
              okind_d  = KIND_SUM;
              otask_d  = TASK_FIELD_W'(in_task);
              omatch_d = chk.matched;
              oflags_d = flag_d;
              ototal_d = TOTAL_W'(cnt_d);
              olast_d  = 1'b1;
            end
            CMD_NOTIFY: begin
              flag_d  = in_setbits ? (flag_q | in_mask) : (flag_q & ~in_mask);
              step_d  = cnt_q;
              final_d = cnt_q;
              state_d = ST_SCAN;
            end
            CMD_FLUSH: begin
              state_d = ST_FLUSH;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        chk_mode = head_mode;
        chk_mask = head_mask;
        if (step_q == '0) begin
          step_d  = cnt_q;
          state_d = ST_EMIT;
        end else begin
          flag_d    = chk.flags_next;
          shift     = 1'b1;
          load_en   = 1'b1;
          load_data = {chk.ok, head_task, head_mode, chk.ok ? chk.matched : head_mask};
          step_d    = step_q - CNT_W'(1);
          if (chk.ok) begin
            final_d = final_q - CNT_W'(1);
          end
        end
      end
      ST_EMIT: begin
        if (step_q == '0) begin
          state_d = ST_SUM;
        end else if (!head_woken) begin
          shift   = 1'b1;
          load_en = 1'b1;
          step_d  = step_q - CNT_W'(1);
        end else if (out_free) begin
          shift    = 1'b1;
          cnt_d    = cnt_q - CNT_W'(1);
          step_d   = step_q - CNT_W'(1);
          ov_d     = 1'b1;
          okind_d  = KIND_WOKEN;
          otask_d  = TASK_FIELD_W'(head_task);
          ostat_d  = STAT_OK;
          omatch_d = head_mask;
          oflags_d = flag_q;
          ototal_d = TOTAL_W'(final_q);
          olast_d  = 1'b0;
        end
      end
      ST_FLUSH: begin
        if (cnt_q == '0) begin
          state_d = ST_SUM;
        end else if (out_free) begin
          shift    = 1'b1;
          cnt_d    = cnt_q - CNT_W'(1);
          ov_d     = 1'b1;
          okind_d  = KIND_REL;
          otask_d  = TASK_FIELD_W'(head_task);
          ostat_d  = STAT_DELETED;
          omatch_d = '0;
          oflags_d = flag_q;
          ototal_d = '0;
          olast_d  = 1'b0;
        end
      end
      ST_SUM: begin
        if (out_free) begin
          ov_d     = 1'b1;
          okind_d  = KIND_SUM;
          otask_d  = '0;
          ostat_d  = STAT_OK;
          omatch_d = '0;
          oflags_d = flag_q;
          ototal_d = TOTAL_W'(cnt_q);
          olast_d  = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cfg_wr) begin
      ini_d  = pwdata;
      flag_d = pwdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      step_q  <= '0;
      final_q <= '0;
      flag_q  <= '0;
      ini_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      step_q  <= step_d;
      final_q <= final_d;
      flag_q  <= flag_d;
      ini_q   <= ini_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    okind_q  <= okind_d;
    otask_q  <= otask_d;
    ostat_q  <= ostat_d;
    omatch_q <= omatch_d;
    oflags_q <= oflags_d;
    ototal_q <= ototal_d;
    olast_q  <= olast_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tuser  = okind_q;
  assign m_axis_tlast  = olast_q;
  assign m_axis_tdata  = {1'b0, ototal_q, oflags_q, omatch_q, ostat_q, otask_q};

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(WAITERS))
    else $error("waiter count beyond chain length");

  a_last_is_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == KIND_SUM)
    else $error("final result of a request is not a summary");

  a_wait_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_cmd == CMD_WAIT || in_cmd == CMD_TRY)
      |=> m_axis_tvalid && m_axis_tlast && state_q == ST_IDLE)
    else $error("wait or try request not answered in one cycle");
`endif

endmodule

`default_nettype wire
